/* rtl/hdb_pkg.sv */
`default_nettype none

package hdb_pkg;

    // Row kinds carried on the input request
    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_NULL  = 2'd1;
    localparam logic [1:0] KIND_NOP   = 2'd2;
    localparam logic [1:0] KIND_UNSUP = 2'd3;

    // Result status codes
    typedef enum logic [2:0] {
        ST_MATCH = 3'd0,
        ST_NEW   = 3'd1,
        ST_NULL  = 3'd2,
        ST_NOP   = 3'd3,
        ST_UNSUP = 3'd4,
        ST_ABORT = 3'd5
    } t_status;

    // Configuration register indexes and port widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTINCT_LIMIT = 2'd1;

    // Verdict of the chain compare unit on one entry
    typedef struct packed {
        logic linked;   // entry belongs to the bucket being walked
        logic hit;      // linked and the key is equal
    } t_probe;

endpackage

`default_nettype wire

/* rtl/hdb_ram.sv */
`default_nettype none

module hdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/hdb_probe.sv */
`default_nettype none

module hdb_probe #(
    parameter int KEY_WIDTH = 64,
    parameter int BKT_W     = 10
) (
    input  wire logic                 i_check_bucket,
    input  wire logic [KEY_WIDTH-1:0] i_entry_key,
    input  wire logic [BKT_W-1:0]     i_entry_bucket,
    input  wire logic [KEY_WIDTH-1:0] i_key,
    input  wire logic [BKT_W-1:0]     i_bucket,
    output hdb_pkg::t_probe           o_result
);

    import hdb_pkg::*;

    logic bucket_eq;
    logic key_eq;

    // A chain head read from the bucket store is only trusted when the
    // entry it names was linked into this same bucket in the current column
    assign bucket_eq = (i_entry_bucket == i_bucket);
    assign key_eq    = (i_entry_key == i_key);

    assign o_result.linked = !i_check_bucket || bucket_eq;
    assign o_result.hit    = o_result.linked && key_eq;

endmodule

`default_nettype wire

/* rtl/hash_dictionary_builder_core.sv */
`default_nettype none

// Null, nop, unsupported and aborted rows go from S_IDLE straight to S_DONE; a value row goes
// through S_HEAD and, if the head is live, S_PROBE (one chain entry per cycle) before S_DONE.
// One row at a time; a new row is stalled until the sequencer is back in S_IDLE. The chain walk
// through the entry memory's registered read port and the shared key compare sets the pace.
// Reset (i_rst_n low, synchronous) clears control state, counts and error and sets
// bucket_bits to 10 and distinct_limit to 1024; memories are not swept, heads are validated.
module hash_dictionary_builder_core #(
    parameter int BUCKET_COUNT = 1024,
    parameter int ENTRY_COUNT  = 1024,
    parameter int KEY_WIDTH    = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // row requests
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_start_column,
    input  wire logic [1:0]                         i_row_kind,
    input  wire logic [63:0]                        i_key_value,
    input  wire logic [63:0]                        i_hash_value,
    // results
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [2:0]                              o_status,
    output logic [9:0]                              o_dict_index,
    output logic [10:0]                             o_distinct_count,
    output logic [15:0]                             o_null_count,
    output logic [15:0]                             o_nop_count,
    // configuration writes
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [hdb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [hdb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import hdb_pkg::*;

    localparam int BW = $clog2(BUCKET_COUNT);
    localparam int EW = $clog2(ENTRY_COUNT);
    localparam int UW = $clog2(ENTRY_COUNT + 1);
    localparam int CW = (UW > CFG_DATA_W) ? UW : CFG_DATA_W;

    // Entry word layout: {bucket, rows, next valid, next index, key}
    localparam int KEY_LO  = 0;
    localparam int NEXT_LO = KEY_WIDTH;
    localparam int NEXT_V  = KEY_WIDTH + EW;
    localparam int ROWS_LO = NEXT_V + 1;
    localparam int BKT_LO  = ROWS_LO + 16;
    localparam int ENT_W   = BKT_LO + BW;

    localparam logic [BW-1:0] BKT_RANGE_MASK = BW'(BUCKET_COUNT - 1);
    localparam logic [CW-1:0] ENTRY_CAP      = CW'(ENTRY_COUNT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_PROBE,
        S_DONE
    } t_state;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Registers
    t_state             r_state, n_state;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [BW-1:0]      r_bucket, n_bucket;
    logic               r_head_valid, n_head_valid;
    logic [EW-1:0]      r_head_idx, n_head_idx;
    logic               r_first, n_first;
    logic [EW-1:0]      r_cur_idx, n_cur_idx;
    logic [UW-1:0]      r_used, n_used;
    logic [15:0]        r_nulls, n_nulls;
    logic [15:0]        r_nops, n_nops;
    logic               r_err, n_err;
    t_status            r_res_status, n_res_status;
    logic [EW-1:0]      r_res_dict, n_res_dict;
    logic               r_out_valid, n_out_valid;
    logic [2:0]         r_out_status, n_out_status;
    logic [9:0]         r_out_dict, n_out_dict;
    logic [10:0]        r_out_count, n_out_count;
    logic [15:0]        r_out_nulls, n_out_nulls;
    logic [15:0]        r_out_nops, n_out_nops;
    logic [3:0]         r_bucket_bits;
    logic [10:0]        r_distinct_limit;

    // Memory ports
    logic               bkt_we;
    logic [BW-1:0]      bkt_waddr;
    logic [EW-1:0]      bkt_wdata;
    logic [BW-1:0]      bkt_raddr;
    logic [EW-1:0]      bkt_rdata;
    logic               ent_we;
    logic [EW-1:0]      ent_waddr;
    logic [ENT_W-1:0]   ent_wdata;
    logic [EW-1:0]      ent_raddr;
    logic [ENT_W-1:0]   ent_rdata;

    // Combinational helpers
    logic               in_accept;
    logic               cfg_write;
    logic [BW-1:0]      acc_bucket;
    logic [CW-1:0]      limit;
    logic [UW-1:0]      eff_used;
    logic               eff_err;
    logic [15:0]        eff_nulls;
    logic [15:0]        eff_nops;
    logic               do_insert;
    logic               ins_next_v;
    logic [EW-1:0]      used_idx;
    t_probe             probe;
    logic [31:0]        dict_wide;
    logic [31:0]        used_wide;

    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign used_idx    = r_used[EW-1:0];

    // Bucket index: hash masked to bucket_bits and to the bucket store
    always_comb begin
        acc_bucket = '0;
        for (int i = 0; i < BW; i++) begin
            acc_bucket[i] = i_hash_value[i] && (i < int'(r_bucket_bits))
                            && BKT_RANGE_MASK[i];
        end
    end

    // Effective distinct limit, capped at the entry store
    always_comb begin
        limit = CW'(r_distinct_limit);
        if (limit > ENTRY_CAP) begin
            limit = ENTRY_CAP;
        end
    end

    // Column state as seen by an incoming row, after an optional clear
    assign eff_used  = i_start_column ? '0 : r_used;
    assign eff_err   = i_start_column ? 1'b0 : r_err;
    assign eff_nulls = i_start_column ? '0 : r_nulls;
    assign eff_nops  = i_start_column ? '0 : r_nops;

    // Shared chain compare unit
    hdb_probe #(
        .KEY_WIDTH (KEY_WIDTH),
        .BKT_W     (BW)
    ) u_probe (
        .i_check_bucket (r_first),
        .i_entry_key    (ent_rdata[KEY_LO +: KEY_WIDTH]),
        .i_entry_bucket (ent_rdata[BKT_LO +: BW]),
        .i_key          (r_key),
        .i_bucket       (r_bucket),
        .o_result       (probe)
    );

    // Sequencer next state
    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_bucket     = r_bucket;
        n_head_valid = r_head_valid;
        n_head_idx   = r_head_idx;
        n_first      = r_first;
        n_cur_idx    = r_cur_idx;
        n_used       = r_used;
        n_nulls      = r_nulls;
        n_nops       = r_nops;
        n_err        = r_err;
        n_res_status = r_res_status;
        n_res_dict   = r_res_dict;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_dict   = r_out_dict;
        n_out_count  = r_out_count;
        n_out_nulls  = r_out_nulls;
        n_out_nops   = r_out_nops;

        bkt_we     = 1'b0;
        bkt_waddr  = r_bucket;
        bkt_wdata  = used_idx;
        bkt_raddr  = acc_bucket;
        ent_we     = 1'b0;
        ent_waddr  = r_cur_idx;
        ent_wdata  = ent_rdata;
        ent_raddr  = r_cur_idx;
        do_insert  = 1'b0;
        ins_next_v = 1'b0;
        dict_wide  = 32'(r_res_dict);
        used_wide  = 32'(r_used);

        // Result register drains independently
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_key      = i_key_value[KEY_WIDTH-1:0];
                    n_bucket   = acc_bucket;
                    n_first    = 1'b1;
                    n_used     = eff_used;
                    n_err      = eff_err;
                    n_nulls    = eff_nulls;
                    n_nops     = eff_nops;
                    n_res_dict = '0;
                    if (eff_err) begin
                        n_res_status = ST_UNSUP;
                        n_state      = S_DONE;
                    end else if (CW'(eff_used) >= limit) begin
                        n_res_status = ST_ABORT;
                        n_state      = S_DONE;
                    end else begin
                        case (i_row_kind)
                            KIND_NULL: begin
                                n_nulls      = sat_inc16(eff_nulls);
                                n_res_status = ST_NULL;
                                n_state      = S_DONE;
                            end
                            KIND_NOP: begin
                                n_nops       = sat_inc16(eff_nops);
                                n_res_status = ST_NOP;
                                n_state      = S_DONE;
                            end
                            KIND_UNSUP: begin
                                n_err        = 1'b1;
                                n_res_status = ST_UNSUP;
                                n_state      = S_DONE;
                            end
                            default: begin
                                n_state = S_HEAD;
                            end
                        endcase
                    end
                end
            end

            // Head read back: trust it only if it names a live entry
            S_HEAD: begin
                n_head_idx   = bkt_rdata;
                n_head_valid = (UW'(bkt_rdata) < r_used);
                if (UW'(bkt_rdata) < r_used) begin
                    ent_raddr = bkt_rdata;
                    n_cur_idx = bkt_rdata;
                    n_state   = S_PROBE;
                end else begin
                    do_insert  = 1'b1;
                    ins_next_v = 1'b0;
                end
            end

            // One chain entry per cycle through the compare unit
            S_PROBE: begin
                if (probe.hit) begin
                    ent_we    = 1'b1;
                    ent_waddr = r_cur_idx;
                    ent_wdata = ent_rdata;
                    ent_wdata[ROWS_LO +: 16] = sat_inc16(ent_rdata[ROWS_LO +: 16]);
                    n_res_status = ST_MATCH;
                    n_res_dict   = r_cur_idx;
                    n_state      = S_DONE;
                end else if (probe.linked && ent_rdata[NEXT_V]) begin
                    ent_raddr = ent_rdata[NEXT_LO +: EW];
                    n_cur_idx = ent_rdata[NEXT_LO +: EW];
                    n_first   = 1'b0;
                end else begin
                    do_insert  = 1'b1;
                    ins_next_v = r_head_valid && !(r_first && !probe.linked);
                end
            end

            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_dict   = dict_wide[9:0];
                    n_out_count  = used_wide[10:0];
                    n_out_nulls  = r_nulls;
                    n_out_nops   = r_nops;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Miss: new entry at the head of the bucket chain
        if (do_insert) begin
            ent_we    = 1'b1;
            ent_waddr = used_idx;
            ent_wdata = {r_bucket, 16'd1, ins_next_v, r_head_idx, r_key};
            bkt_we    = 1'b1;
            bkt_waddr = r_bucket;
            bkt_wdata = used_idx;
            n_used       = r_used + UW'(1);
            n_res_status = ST_NEW;
            n_res_dict   = used_idx;
            n_state      = S_DONE;
        end
    end

    // State, counters, result register and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_used           <= '0;
            r_nulls          <= '0;
            r_nops           <= '0;
            r_err            <= 1'b0;
            r_out_valid      <= 1'b0;
            r_bucket_bits    <= 4'd10;
            r_distinct_limit <= 11'd1024;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_nulls     <= n_nulls;
            r_nops      <= n_nops;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            if (cfg_write && (i_cfg_index == CFG_BUCKET_BITS)) begin
                r_bucket_bits <= i_cfg_data[3:0];
            end
            if (cfg_write && (i_cfg_index == CFG_DISTINCT_LIMIT)) begin
                r_distinct_limit <= i_cfg_data[10:0];
            end
        end
        r_key        <= n_key;
        r_bucket     <= n_bucket;
        r_head_valid <= n_head_valid;
        r_head_idx   <= n_head_idx;
        r_first      <= n_first;
        r_cur_idx    <= n_cur_idx;
        r_res_status <= n_res_status;
        r_res_dict   <= n_res_dict;
        r_out_status <= n_out_status;
        r_out_dict   <= n_out_dict;
        r_out_count  <= n_out_count;
        r_out_nulls  <= n_out_nulls;
        r_out_nops   <= n_out_nops;
    end

    // Bucket heads
    hdb_ram #(
        .WIDTH (EW),
        .DEPTH (BUCKET_COUNT)
    ) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (bkt_we),
        .i_waddr (bkt_waddr),
        .i_wdata (bkt_wdata),
        .i_raddr (bkt_raddr),
        .o_rdata (bkt_rdata)
    );

    // Entries: key, chain link, row count and owning bucket
    hdb_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRY_COUNT)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_dict_index     = r_out_dict;
    assign o_distinct_count = r_out_count;
    assign o_null_count     = r_out_nulls;
    assign o_nop_count      = r_out_nops;

`ifndef SYNTH
    // Entry count never passes the store size
    a_used_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_used) <= ENTRY_CAP)
        else $error("entry count beyond store size");

    // A reported dictionary number always names a live entry
    a_dict_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (r_res_status == ST_MATCH || r_res_status == ST_NEW))
        |-> (UW'(r_res_dict) < r_used))
        else $error("dictionary number not below entry count");

    // A start row clears the entry count before anything else happens
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_start_column) |=> (r_used == '0))
        else $error("start row did not clear entry count");

    // A head update always comes with the new entry at the next free slot
    a_insert_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bkt_we |-> (ent_we && ent_waddr == used_idx && bkt_wdata == used_idx))
        else $error("bucket head written without matching entry");

    // With the error latched, nothing is added until a start row
    a_err_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && !(in_accept && i_start_column)) |=> $stable(r_used))
        else $error("entry count moved while error latched");
`endif

endmodule

`default_nettype wire
